// File: rtl/qrs_pkg.sv
// Shared types and constants of the quadratic root solver.
package qrs_pkg;

	localparam int COEF_W   = 32;
	localparam int ROOT_W   = 48;
	localparam int FRAC_W   = 20;
	localparam int TOL_W    = 10;
	localparam int MAG_W    = 64;                // |b|^2 and |a||c|
	localparam int DISC_W   = 66;                // |b^2 - 4ac|
	localparam int DEN_W    = COEF_W + 1;        // |2a|
	localparam int PNUM_W   = COEF_W + FRAC_W;   // |b| * 2^20
	localparam int SQ_BITS  = 57;                // bits of floor(sqrt(|d| * 2^40))
	localparam int SQ_W     = 2 * SQ_BITS;       // radicand and trial width
	localparam int SQ_SHIFT = 2 * FRAC_W;
	localparam int SUM_W    = SQ_BITS + 2;       // signed p +/- q

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [ROOT_W-1:0] root_t;
	typedef logic [TOL_W-1:0] tol_t;

	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_DOUBLE  = 2'd1,
		KIND_REAL    = 2'd2,
		KIND_COMPLEX = 2'd3
	} root_kind_t;

	localparam logic REG_ZERO_SNAP = 1'b0;
	localparam logic REG_EQUAL_TOL = 1'b1;

	localparam tol_t SNAP_RESET = 10'd5;
	localparam tol_t TOL_RESET  = 10'd5;

	localparam root_t ROOT_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam root_t ROOT_MIN = 48'sh8000_0000_0000;

endpackage

// File: rtl/qrs_coef_if.sv
// Channel that carries the three coefficients of one equation.
interface qrs_coef_if import qrs_pkg::*; ();
	logic  valid;
	logic  ready;
	coef_t coef_a;
	coef_t coef_b;
	coef_t coef_c;

	modport source (output valid, coef_a, coef_b, coef_c, input ready);
	modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

// File: rtl/qrs_root_if.sv
// Channel that carries the roots of one equation.
interface qrs_root_if import qrs_pkg::*; ();
	logic       valid;
	logic       ready;
	root_kind_t root_kind;
	root_t      root_one;
	root_t      root_two;
	root_t      imag_part;
	logic       saturated;

	modport source (output valid, root_kind, root_one, root_two, imag_part, saturated,
		input ready);
	modport sink (input valid, root_kind, root_one, root_two, imag_part, saturated,
		output ready);
endinterface

// File: rtl/quadratic_root_solver.sv
// Pipelined solver for the roots of a*x^2 + b*x + c = 0.
//
//   channel   direction  transfer
//   coef_ch   in         coef_a, coef_b, coef_c (signed Q16.16)
//   root_ch   out        root_kind, root_one, root_two, imag_part, saturated
//   apb       in/out     zero_snap_lsb at 0x0, equal_tol_lsb at 0x4
//
// One equation enters per cycle while the pipeline is not held; the stages are products,
// discriminant, 57 square-root stages (the -b/2a divider runs alongside), 57 divider stages for
// sqrt/2a, and three stages of saturation, snapping and selection.
// Reset clears the valid bits and loads both registers with 5.
// The whole pipeline holds while the output register is full and not taken.
module quadratic_root_solver import qrs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	qrs_coef_if.sink          coef_ch,
	qrs_root_if.source        root_ch
);

	typedef struct packed {
		logic             a_zero;
		logic             d_zero;
		logic             d_neg;
		logic             p_neg;
		logic             q_neg;
		logic [DEN_W-1:0] den;
	} ctl_t;

	tol_t snap_q;
	tol_t tol_q;
	logic en;

	// Configuration registers.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_q <= SNAP_RESET;
			tol_q  <= TOL_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_ZERO_SNAP: snap_q <= pwdata[TOL_W-1:0];
				REG_EQUAL_TOL: tol_q  <= pwdata[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ZERO_SNAP: prdata = 32'(snap_q);
			REG_EQUAL_TOL: prdata = 32'(tol_q);
			default:       prdata = '0;
		endcase
	end

	logic v_s5;
	assign en = !v_s5 || root_ch.ready;
	assign coef_ch.ready = en;

	// Stage 1: magnitudes and products.
	logic [COEF_W-1:0] amag, bmag, cmag;
	assign amag = coef_ch.coef_a[COEF_W-1] ? COEF_W'(-coef_ch.coef_a) : coef_ch.coef_a;
	assign bmag = coef_ch.coef_b[COEF_W-1] ? COEF_W'(-coef_ch.coef_b) : coef_ch.coef_b;
	assign cmag = coef_ch.coef_c[COEF_W-1] ? COEF_W'(-coef_ch.coef_c) : coef_ch.coef_c;

	logic              v_s1;
	logic [MAG_W-1:0]  bb_s1, ac_s1;
	logic              ac_neg_s1;
	ctl_t              ctl_s1;
	logic [PNUM_W-1:0] pnum_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= coef_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bb_s1     <= MAG_W'(bmag) * MAG_W'(bmag);
			ac_s1     <= MAG_W'(amag) * MAG_W'(cmag);
			ac_neg_s1 <= (coef_ch.coef_a[COEF_W-1] != coef_ch.coef_c[COEF_W-1])
				&& (coef_ch.coef_c != '0);
			ctl_s1.a_zero <= (coef_ch.coef_a == '0);
			ctl_s1.d_zero <= 1'b0;
			ctl_s1.d_neg  <= 1'b0;
			// -b/2a is negative when a and b share a sign.
			ctl_s1.p_neg  <= !(coef_ch.coef_a[COEF_W-1] ^ coef_ch.coef_b[COEF_W-1]);
			ctl_s1.q_neg  <= coef_ch.coef_a[COEF_W-1];
			ctl_s1.den    <= {amag, 1'b0};
			pnum_s1       <= {bmag, {FRAC_W{1'b0}}};
		end
	end

	// Stage 2: discriminant magnitude and sign.
	logic [DISC_W-1:0] bb_w, fac_w, disc_w;
	logic              dneg_w;
	ctl_t              ctl_d_w;
	assign bb_w  = DISC_W'(bb_s1);
	assign fac_w = {ac_s1, 2'b00};

	always_comb begin
		dneg_w = 1'b0;
		if (ac_neg_s1) begin
			disc_w = bb_w + fac_w;
		end else if (bb_w >= fac_w) begin
			disc_w = bb_w - fac_w;
		end else begin
			disc_w = fac_w - bb_w;
			dneg_w = 1'b1;
		end
		ctl_d_w        = ctl_s1;
		ctl_d_w.d_neg  = dneg_w;
		ctl_d_w.d_zero = (disc_w == '0);
	end

	logic              v_s2;
	logic [DISC_W-1:0] disc_s2;
	ctl_t              ctl_s2;
	logic [PNUM_W-1:0] pnum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			disc_s2 <= disc_w;
			ctl_s2  <= ctl_d_w;
			pnum_s2 <= pnum_s1;
		end
	end

	// Square-root stages, one result bit each, most significant first.
	// The -b/2a restoring divider shares the first PNUM_W of these stages, one quotient bit each.
	logic              sq_v_s    [SQ_BITS];
	logic [SQ_W-1:0]   sq_rem_s  [SQ_BITS];
	logic [SQ_BITS-1:0] sq_root_s [SQ_BITS];
	ctl_t              sq_ctl_s  [SQ_BITS];
	logic [PNUM_W-1:0] pd_num_s  [SQ_BITS];
	logic [DEN_W-1:0]  pd_rem_s  [SQ_BITS];
	logic [PNUM_W-1:0] pd_quo_s  [SQ_BITS];

	for (genvar i = 0; i < SQ_BITS; i++) begin : g_sq
		localparam int K = SQ_BITS - 1 - i;
		logic               v_i;
		logic [SQ_W-1:0]    rem_i, trial;
		logic [SQ_BITS-1:0] root_i;
		ctl_t               ctl_i;
		logic [PNUM_W-1:0]  num_i, quo_i, quo_n;
		logic [DEN_W-1:0]   prem_i, prem_n;
		logic               ge;

		if (i == 0) begin : g_first
			assign v_i    = v_s2;
			assign rem_i  = SQ_W'(disc_s2) << SQ_SHIFT;
			assign root_i = '0;
			assign ctl_i  = ctl_s2;
			assign num_i  = pnum_s2;
			assign prem_i = '0;
			assign quo_i  = '0;
		end else begin : g_next
			assign v_i    = sq_v_s[i-1];
			assign rem_i  = sq_rem_s[i-1];
			assign root_i = sq_root_s[i-1];
			assign ctl_i  = sq_ctl_s[i-1];
			assign num_i  = pd_num_s[i-1];
			assign prem_i = pd_rem_s[i-1];
			assign quo_i  = pd_quo_s[i-1];
		end

		// (r + 2^K)^2 - r^2 = r * 2^(K+1) + 2^(2K), with r zero below bit K.
		assign trial = (SQ_W'(root_i) << (K + 1)) | (SQ_W'(1) << (2 * K));
		assign ge    = (rem_i >= trial);

		if (i < PNUM_W) begin : g_pdiv
			localparam int J = PNUM_W - 1 - i;
			logic [DEN_W:0] r2;
			logic           pge;
			assign r2     = {prem_i, num_i[J]};
			assign pge    = (r2 >= {1'b0, ctl_i.den});
			assign prem_n = pge ? DEN_W'(r2 - {1'b0, ctl_i.den}) : r2[DEN_W-1:0];
			assign quo_n  = quo_i | (PNUM_W'(pge) << J);
		end else begin : g_pidle
			assign prem_n = prem_i;
			assign quo_n  = quo_i;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v_s[i] <= 1'b0;
			else if (en) sq_v_s[i] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem_s[i]  <= ge ? rem_i - trial : rem_i;
				sq_root_s[i] <= root_i | (SQ_BITS'(ge) << K);
				sq_ctl_s[i]  <= ctl_i;
				pd_num_s[i]  <= num_i;
				pd_rem_s[i]  <= prem_n;
				pd_quo_s[i]  <= quo_n;
			end
		end
	end

	// Divider stages for sqrt(|d|) / |2a|, one quotient bit each.
	logic               dv_v_s   [SQ_BITS];
	logic [SQ_BITS-1:0] dv_num_s [SQ_BITS];
	logic [DEN_W-1:0]   dv_rem_s [SQ_BITS];
	logic [SQ_BITS-1:0] dv_quo_s [SQ_BITS];
	logic [PNUM_W-1:0]  dv_p_s   [SQ_BITS];
	ctl_t               dv_ctl_s [SQ_BITS];

	for (genvar i = 0; i < SQ_BITS; i++) begin : g_dv
		localparam int J = SQ_BITS - 1 - i;
		logic               v_i;
		logic [SQ_BITS-1:0] num_i, quo_i;
		logic [DEN_W-1:0]   rem_i;
		logic [PNUM_W-1:0]  p_i;
		ctl_t               ctl_i;
		logic [DEN_W:0]     r2;
		logic               ge;

		if (i == 0) begin : g_first
			assign v_i   = sq_v_s[SQ_BITS-1];
			assign num_i = sq_root_s[SQ_BITS-1];
			assign rem_i = '0;
			assign quo_i = '0;
			assign p_i   = pd_quo_s[SQ_BITS-1];
			assign ctl_i = sq_ctl_s[SQ_BITS-1];
		end else begin : g_next
			assign v_i   = dv_v_s[i-1];
			assign num_i = dv_num_s[i-1];
			assign rem_i = dv_rem_s[i-1];
			assign quo_i = dv_quo_s[i-1];
			assign p_i   = dv_p_s[i-1];
			assign ctl_i = dv_ctl_s[i-1];
		end

		assign r2 = {rem_i, num_i[J]};
		assign ge = (r2 >= {1'b0, ctl_i.den});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[i] <= 1'b0;
			else if (en) dv_v_s[i] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_num_s[i] <= num_i;
				dv_rem_s[i] <= ge ? DEN_W'(r2 - {1'b0, ctl_i.den}) : r2[DEN_W-1:0];
				dv_quo_s[i] <= quo_i | (SQ_BITS'(ge) << J);
				dv_p_s[i]   <= p_i;
				dv_ctl_s[i] <= ctl_i;
			end
		end
	end

	function automatic logic [ROOT_W:0] clip_root(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi, lo;
		hi = SUM_W'(ROOT_MAX);
		lo = SUM_W'(ROOT_MIN);
		if (v > hi) return {1'b1, ROOT_MAX};
		else if (v < lo) return {1'b1, ROOT_MIN};
		else return {1'b0, v[ROOT_W-1:0]};
	endfunction

	function automatic logic [ROOT_W-1:0] abs_root(input root_t v);
		return v[ROOT_W-1] ? ROOT_W'(-v) : v;
	endfunction

	function automatic root_t snap_root(input root_t v, input tol_t th);
		return (abs_root(v) < ROOT_W'(th)) ? '0 : v;
	endfunction

	// Stage 3: signed p and q, both sums, saturation.
	logic signed [SUM_W-1:0] pext, qext, pv, qv;
	logic [ROOT_W:0]         c_sum, c_dif, c_p, c_q;
	ctl_t                    ctl_w;

	assign ctl_w = dv_ctl_s[SQ_BITS-1];
	assign pext  = SUM_W'(dv_p_s[SQ_BITS-1]);
	assign qext  = SUM_W'(dv_quo_s[SQ_BITS-1]);
	assign pv    = ctl_w.p_neg ? -pext : pext;
	assign qv    = ctl_w.q_neg ? -qext : qext;
	assign c_sum = clip_root(pv + qv);
	assign c_dif = clip_root(pv - qv);
	assign c_p   = clip_root(pv);
	assign c_q   = clip_root(qv);

	logic  v_s3;
	root_t x1_s3, x2_s3, p_s3, q_s3;
	logic  f1_s3, f2_s3, fp_s3, fq_s3;
	ctl_t  ctl_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= dv_v_s[SQ_BITS-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			{f1_s3, x1_s3} <= c_sum;
			{f2_s3, x2_s3} <= c_dif;
			{fp_s3, p_s3}  <= c_p;
			{fq_s3, q_s3}  <= c_q;
			ctl_s3         <= ctl_w;
		end
	end

	// Stage 4: snap small roots to zero.
	logic  v_s4;
	root_t x1_s4, x2_s4, p_s4, q_s4;
	logic  f1_s4, f2_s4, fp_s4, fq_s4;
	ctl_t  ctl_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s4  <= snap_root(x1_s3, snap_q);
			x2_s4  <= snap_root(x2_s3, snap_q);
			p_s4   <= snap_root(p_s3, snap_q);
			q_s4   <= q_s3;
			f1_s4  <= f1_s3;
			f2_s4  <= f2_s3;
			fp_s4  <= fp_s3;
			fq_s4  <= fq_s3;
			ctl_s4 <= ctl_s3;
		end
	end

	// Stage 5: pick the kind of result; this is the output register.
	logic signed [ROOT_W:0] rdif;
	logic [ROOT_W:0]        rdif_mag;
	logic                   near_real, near_imag;
	root_kind_t             kind_w;
	root_t                  r1_w, r2_w, im_w;
	logic                   sat_w;

	assign rdif      = (ROOT_W+1)'(x1_s4) - (ROOT_W+1)'(x2_s4);
	assign rdif_mag  = rdif[ROOT_W] ? (ROOT_W+1)'(-rdif) : rdif;
	assign near_real = (rdif_mag < (ROOT_W+1)'(tol_q));
	assign near_imag = (abs_root(q_s4) < ROOT_W'(tol_q));

	always_comb begin
		kind_w = KIND_NONE;
		r1_w   = '0;
		r2_w   = '0;
		im_w   = '0;
		sat_w  = 1'b0;
		if (ctl_s4.a_zero) begin
			kind_w = KIND_NONE;
		end else if (ctl_s4.d_zero) begin
			kind_w = KIND_DOUBLE;
			r1_w   = p_s4;
			r2_w   = p_s4;
			sat_w  = fp_s4;
		end else if (!ctl_s4.d_neg) begin
			r1_w = x1_s4;
			if (near_real) begin
				kind_w = KIND_DOUBLE;
				r2_w   = x1_s4;
				sat_w  = f1_s4;
			end else begin
				kind_w = KIND_REAL;
				r2_w   = x2_s4;
				sat_w  = f1_s4 || f2_s4;
			end
		end else begin
			r1_w = p_s4;
			r2_w = p_s4;
			if (near_imag) begin
				kind_w = KIND_DOUBLE;
				sat_w  = fp_s4;
			end else begin
				kind_w = KIND_COMPLEX;
				im_w   = q_s4;
				sat_w  = fp_s4 || fq_s4;
			end
		end
	end

	root_kind_t kind_s5;
	root_t      r1_s5, r2_s5, im_s5;
	logic       sat_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s5 <= kind_w;
			r1_s5   <= r1_w;
			r2_s5   <= r2_w;
			im_s5   <= im_w;
			sat_s5  <= sat_w;
		end
	end

	assign root_ch.valid     = v_s5;
	assign root_ch.root_kind = kind_s5;
	assign root_ch.root_one  = r1_s5;
	assign root_ch.root_two  = r2_s5;
	assign root_ch.imag_part = im_s5;
	assign root_ch.saturated = sat_s5;

	a_none_clean: assert property (@(posedge clk) disable iff (!arst_n)
		root_ch.valid && root_ch.root_kind == KIND_NONE |->
			root_ch.root_one == '0 && root_ch.root_two == '0
			&& root_ch.imag_part == '0 && !root_ch.saturated)
		else $error("not-quadratic result carries nonzero data");

	a_double_same: assert property (@(posedge clk) disable iff (!arst_n)
		root_ch.valid && root_ch.root_kind == KIND_DOUBLE |->
			root_ch.root_one == root_ch.root_two && root_ch.imag_part == '0)
		else $error("double root with differing values");

	a_real_imag: assert property (@(posedge clk) disable iff (!arst_n)
		root_ch.valid && root_ch.root_kind == KIND_REAL |-> root_ch.imag_part == '0)
		else $error("real roots with an imaginary part");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!coef_ch.ready |-> root_ch.valid && !root_ch.ready)
		else $error("input held off without a stalled output");

endmodule
